// ===== hdl/cop_pkg.sv =====
package cop_pkg;

    localparam int COORD_W     = 12;
    localparam int SIDE_W      = 13;
    localparam int RAD_W       = 4;
    localparam int OFF_W       = RAD_W + 1;
    localparam int SQ_W        = 2 * RAD_W;
    localparam int VALUE_W     = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int MAX_RADIUS_DEF = 8;
    localparam int MAX_SIDE_DEF   = 4096;
    localparam int SIDE_CAP       = 4096;
    localparam int SIDE_FLOOR     = 16;

    localparam logic [SIDE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIDE_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0]        centre_col;
        logic [COORD_W-1:0]        centre_row;
        logic [RAD_W-1:0]          radius;
        logic signed [VALUE_W-1:0] paint_value;
    } cop_cmd_word_t;

    typedef struct packed {
        logic [COORD_W-1:0]        pixel_row;
        logic [COORD_W-1:0]        pixel_col;
        logic signed [VALUE_W-1:0] pixel_value;
        logic                      last_pixel;
    } cop_pix_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_EMIT
    } cop_state_t;

    typedef enum logic [1:0] {
        PH_ROW_POS,
        PH_ROW_NEG,
        PH_COL_POS,
        PH_COL_NEG
    } cop_phase_t;

    typedef struct packed {
        logic load;
        logic emit;
    } cop_ctl_t;

    typedef struct packed {
        logic r_zero;
        logic rem_done;
        logic out_free;
        logic last;
    } cop_sts_t;

    function automatic logic [SIDE_W-1:0] side_limit(
        input logic [SIDE_W-1:0] v,
        input logic [SIDE_W-1:0] hi
    );
        logic [SIDE_W-1:0] res;
        if (v < SIDE_W'(SIDE_FLOOR))
            res = SIDE_W'(SIDE_FLOOR);
        else if (v > hi)
            res = hi;
        else
            res = v;
        return res;
    endfunction

    function automatic logic [RAD_W-1:0] isqrt(input logic [SQ_W-1:0] n);
        logic [RAD_W-1:0] res;
        res = '0;
        for (int k = 1; k <= MAX_RADIUS_DEF; k++)
        begin
            if (int'(n) >= k * k)
                res = RAD_W'(k);
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] wrap_add(
        input logic [COORD_W-1:0]      base,
        input logic signed [OFF_W-1:0] off,
        input logic [SIDE_W-1:0]       size
    );
        logic signed [SIDE_W+1:0] v;
        logic signed [SIDE_W+1:0] sz;
        v  = $signed({{(SIDE_W + 2 - COORD_W){1'b0}}, base})
           + $signed({{(SIDE_W + 2 - OFF_W){off[OFF_W-1]}}, off});
        sz = $signed({2'b00, size});
        if (v < 0)
            v = v + sz;
        else if (v >= sz)
            v = v - sz;
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== hdl/circle_outline_pixel_generator.sv =====
// Circle outline pixel generator.
// cmd channel (cmd_valid / cmd_stall / cmd): one word per circle holding
// centre column, centre row, radius and paint value. A radius above
// MAX_RADIUS draws at MAX_RADIUS; radius 0 is taken while idle and
// draws nothing.
// pix channel (pix_valid / pix_stall / pix): 8*r pixel writes per circle,
// rows and columns already wrapped into the image; last_pixel marks the
// final write of the circle.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// image width, index 1 image height; other indexes are ignored. Write only
// while no circle is in flight. Sizes are clamped to 16..min(4096, MAX_SIDE).
// Timing: after a command is taken, a 12-step remainder unit per axis
// reduces the centre modulo the image size, then one pixel leaves per
// cycle while pix_stall is low; after the final pixel the block returns
// to idle, where it takes the next command. The output register lets
// the next command enter while the final pixel still waits. While
// pix_stall is high with a valid pixel held, the pixel word holds and
// generation pauses. Reset clears the control state and loads 640 x 480.
module circle_outline_pixel_generator #(
    parameter int MAX_RADIUS = cop_pkg::MAX_RADIUS_DEF,
    parameter int MAX_SIDE   = cop_pkg::MAX_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  cop_pkg::cop_cmd_word_t            cmd,
    output logic                              pix_valid,
    input  logic                              pix_stall,
    output cop_pkg::cop_pix_word_t            pix,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cop_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cop_pkg::SIDE_W-1:0]        cfg_data
);
    import cop_pkg::*;

    cop_ctl_t ctl;
    cop_sts_t sts;

    assign cfg_ready = 1'b1;

    cop_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    cop_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .pix_stall (pix_stall),
        .pix_valid (pix_valid),
        .pix       (pix),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

// ===== hdl/cop_rem.sv =====
module cop_rem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cop_pkg::COORD_W-1:0]   dividend,
    input  logic [cop_pkg::SIDE_W-1:0]    divisor,
    output logic [cop_pkg::COORD_W-1:0]   rem,
    output logic                          done
);
    import cop_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] dvd_reg;
    logic [SIDE_W-1:0]  div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [SIDE_W-1:0]  trial;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[COORD_W-1]};
        if (trial >= div_reg)
            trial = trial - div_reg;
        rem_next = trial[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(COORD_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[COORD_W-2:0], 1'b0};
        end
    end

    assign rem  = rem_reg;
    assign done = !busy_reg;

endmodule

// ===== hdl/cop_dp.sv =====
module cop_dp #(
    parameter int MAX_RADIUS = cop_pkg::MAX_RADIUS_DEF,
    parameter int MAX_SIDE   = cop_pkg::MAX_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cop_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cop_pkg::SIDE_W-1:0]        cfg_data,
    input  cop_pkg::cop_cmd_word_t            cmd,
    input  logic                              pix_stall,
    output logic                              pix_valid,
    output cop_pkg::cop_pix_word_t            pix,
    input  cop_pkg::cop_ctl_t                 ctl,
    output cop_pkg::cop_sts_t                 sts
);
    import cop_pkg::*;

    localparam int SideHiInt = (MAX_SIDE < SIDE_CAP) ? MAX_SIDE : SIDE_CAP;
    localparam logic [SIDE_W-1:0] SideHi = SIDE_W'(SideHiInt);
    localparam logic [RAD_W-1:0]  RadMax = RAD_W'(MAX_RADIUS);

    logic [SIDE_W-1:0]         width_reg, height_reg;
    logic [SIDE_W-1:0]         size_w_reg, size_h_reg;
    logic [RAD_W-1:0]          r_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [OFF_W-1:0]   i_reg;
    logic [RAD_W-1:0]          j_reg;
    cop_phase_t                phase_reg;
    cop_pix_word_t             pix_reg;
    logic                      pix_valid_reg, pix_valid_next;

    logic [SIDE_W-1:0]         w_lim, h_lim;
    logic [RAD_W-1:0]          r_sat;
    logic [COORD_W-1:0]        x_mod, y_mod;
    logic                      x_done, y_done;
    logic signed [OFF_W-1:0]   i_inc, i_abs, i_end, j_pos, j_neg, roff, coff;
    logic [SQ_W-1:0]           rr, ii;
    logic [COORD_W-1:0]        row, col;
    logic                      last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_lim = side_limit(width_reg, SideHi);
    assign h_lim = side_limit(height_reg, SideHi);
    assign r_sat = (cmd.radius > RadMax) ? RadMax : cmd.radius;

    cop_rem u_rem_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.load),
        .dividend (cmd.centre_col),
        .divisor  (w_lim),
        .rem      (x_mod),
        .done     (x_done)
    );

    cop_rem u_rem_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.load),
        .dividend (cmd.centre_row),
        .divisor  (h_lim),
        .rem      (y_mod),
        .done     (y_done)
    );

    always_comb
    begin
        i_inc = i_reg + OFF_W'(1);
        i_abs = i_inc[OFF_W-1] ? -i_inc : i_inc;
        ii    = SQ_W'(i_abs[RAD_W-1:0]) * SQ_W'(i_abs[RAD_W-1:0]);
        rr    = SQ_W'(r_reg) * SQ_W'(r_reg);
        i_end = $signed({1'b0, r_reg}) - OFF_W'(1);
        j_pos = $signed({1'b0, j_reg});
        j_neg = OFF_W'(0) - j_pos;
        unique case (phase_reg)
            PH_ROW_POS: begin roff = j_pos; coff = i_reg; end
            PH_ROW_NEG: begin roff = j_neg; coff = i_reg; end
            PH_COL_POS: begin roff = i_reg; coff = j_pos; end
            PH_COL_NEG: begin roff = i_reg; coff = j_neg; end
            default:    begin roff = '0;    coff = '0;    end
        endcase
        row  = wrap_add(y_mod, roff, size_h_reg);
        col  = wrap_add(x_mod, coff, size_w_reg);
        last = (phase_reg == PH_COL_NEG) && (i_reg == i_end);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            size_w_reg <= w_lim;
            size_h_reg <= h_lim;
            r_reg      <= r_sat;
            value_reg  <= cmd.paint_value;
            i_reg      <= OFF_W'(0) - $signed({1'b0, r_sat});
            j_reg      <= '0;
            phase_reg  <= PH_ROW_POS;
        end
        else if (ctl.emit)
        begin
            phase_reg <= cop_phase_t'(phase_reg + 2'd1);
            if (phase_reg == PH_COL_NEG)
            begin
                i_reg <= i_inc;
                j_reg <= isqrt(rr - ii);
            end
        end
    end

    always_comb
    begin
        if (ctl.emit)
            pix_valid_next = 1'b1;
        else if (!pix_stall)
            pix_valid_next = 1'b0;
        else
            pix_valid_next = pix_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else
            pix_valid_reg <= pix_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            pix_reg.pixel_row   <= row;
            pix_reg.pixel_col   <= col;
            pix_reg.pixel_value <= value_reg;
            pix_reg.last_pixel  <= last;
        end
    end

    assign pix_valid    = pix_valid_reg;
    assign pix          = pix_reg;
    assign sts.r_zero   = (cmd.radius == '0);
    assign sts.rem_done = x_done && y_done;
    assign sts.out_free = !pix_valid_reg || !pix_stall;
    assign sts.last     = last;

    a_centre_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> ({1'b0, x_mod} < size_w_reg) && ({1'b0, y_mod} < size_h_reg))
        else $error("centre not reduced below image size at emit");

    a_root_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (j_reg <= r_reg) && (i_reg >= -$signed({1'b0, r_reg})))
        else $error("offset outside circle radius at emit");

endmodule

// ===== hdl/cop_ctrl.sv =====
module cop_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output cop_pkg::cop_ctl_t   ctl,
    input  cop_pkg::cop_sts_t   sts
);
    import cop_pkg::*;

    cop_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !sts.r_zero)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (sts.rem_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        ctl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                ctl.load  = cmd_valid && !sts.r_zero;
            end
            ST_MOD: ;
            ST_EMIT:
            begin
                ctl.emit = sts.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_emit_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> sts.rem_done)
        else $error("emitting before centre reduction finished");

    a_zero_radius_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cmd_valid && sts.r_zero) |=> (state_reg == ST_IDLE))
        else $error("zero radius command left idle");

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cop_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 120;
    localparam int QUIET_LIMIT   = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cmd_valid = 1'b0;
    logic                     cmd_stall;
    cop_cmd_word_t            cmd_word = '0;
    logic                     pix_valid;
    logic                     pix_stall = 1'b0;
    cop_pix_word_t            pix_word;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [SIDE_W-1:0]        cfg_data = '0;

    logic [SIDE_W-1:0] image_width_reg  = WIDTH_RESET;
    logic [SIDE_W-1:0] image_height_reg = HEIGHT_RESET;

    cop_cmd_word_t cmd_pending_q[$];
    cop_pix_word_t pixel_expect_q[$];
    cop_pix_word_t pixel_want;

    bit cmd_gaps_on   = 1'b1;
    bit pix_stalls_on = 1'b1;
    int cmd_gap       = 0;
    int stall_left    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int quiet_cycles  = 0;
    int mismatch_count = 0;

    circle_outline_pixel_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_word),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int clamp_side(input logic [SIDE_W-1:0] v);
        int res;
        res = int'(v);
        if (res < SIDE_FLOOR)
            res = SIDE_FLOOR;
        else if (res > SIDE_CAP)
            res = SIDE_CAP;
        return res;
    endfunction

    function automatic int floor_root(input int n);
        int k;
        k = 0;
        while ((k + 1) * (k + 1) <= n)
            k++;
        return k;
    endfunction

    function automatic logic [COORD_W-1:0] wrap_coord(input int base, input int off,
                                                      input int size);
        return COORD_W'((base % size + size + off) % size);
    endfunction

    function automatic void push_pixel(input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] col,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic last);
        cop_pix_word_t p;
        p.pixel_row   = row;
        p.pixel_col   = col;
        p.pixel_value = value;
        p.last_pixel  = last;
        pixel_expect_q.push_back(p);
    endfunction

    // expand one circle command into its pixel writes
    function automatic void trace_circle(input cop_cmd_word_t c);
        int r;
        int w;
        int h;
        int x;
        int y;
        int j;
        r = int'(c.radius);
        if (r > MAX_RADIUS_DEF)
            r = MAX_RADIUS_DEF;
        w = clamp_side(image_width_reg);
        h = clamp_side(image_height_reg);
        x = int'(c.centre_col);
        y = int'(c.centre_row);
        for (int i = -r; i < r; i++)
        begin
            j = floor_root(r * r - i * i);
            push_pixel(wrap_coord(y, j, h), wrap_coord(x, i, w), c.paint_value, 1'b0);
            push_pixel(wrap_coord(y, -j, h), wrap_coord(x, i, w), c.paint_value, 1'b0);
            push_pixel(wrap_coord(y, i, h), wrap_coord(x, j, w), c.paint_value, 1'b0);
            push_pixel(wrap_coord(y, i, h), wrap_coord(x, -j, w), c.paint_value,
                       i == r - 1);
        end
    endfunction

    function automatic int idle_span();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_centre(input int size);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(size - 8, size - 1);
            2: return $urandom_range(0, size - 1);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // sender: hold a stalled word, otherwise advance after an optional gap
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                trace_circle(cmd_word);
            if (!cmd_valid || !cmd_stall)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap <= cmd_gap - 1;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_pending_q.size() != 0)
                begin
                    cmd_word <= cmd_pending_q.pop_front();
                    cmd_valid <= 1'b1;
                    if (cmd_gaps_on && $urandom_range(0, 1) == 1)
                        cmd_gap <= idle_span();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // receiver: check each pixel word, then choose the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                if (pixel_expect_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected pixel: row %0d col %0d value %0d last %0b",
                                 pix_word.pixel_row, pix_word.pixel_col,
                                 pix_word.pixel_value, pix_word.last_pixel);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    pixel_want = pixel_expect_q.pop_front();
                    if (pix_word.pixel_row !== pixel_want.pixel_row
                        || pix_word.pixel_col !== pixel_want.pixel_col
                        || pix_word.pixel_value !== pixel_want.pixel_value
                        || pix_word.last_pixel !== pixel_want.last_pixel)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $write("pixel mismatch: expected row %0d col %0d value %0d last %0b",
                                   pixel_want.pixel_row, pixel_want.pixel_col,
                                   pixel_want.pixel_value, pixel_want.last_pixel);
                            $display(", got row %0d col %0d value %0d last %0b",
                                     pix_word.pixel_row, pix_word.pixel_col,
                                     pix_word.pixel_value, pix_word.last_pixel);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                pix_stall <= 1'b1;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                stall_left <= HOLD_CYCLES - 1;
                pix_stall <= 1'b1;
            end
            else if (pix_stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left <= idle_span() - 1;
                pix_stall <= 1'b1;
            end
            else
                pix_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIDE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IMAGE_WIDTH)
            image_width_reg = data;
        else if (idx == CFG_IMAGE_HEIGHT)
            image_height_reg = data;
    endtask

    task automatic queue_cmd(input int col, input int row, input int rad, input int value);
        cop_cmd_word_t c;
        c.centre_col  = COORD_W'(col);
        c.centre_row  = COORD_W'(row);
        c.radius      = RAD_W'(rad);
        c.paint_value = VALUE_W'(value);
        cmd_pending_q.push_back(c);
    endtask

    task automatic queue_random(input int count);
        cop_cmd_word_t c;
        int w;
        int h;
        w = clamp_side(image_width_reg);
        h = clamp_side(image_height_reg);
        repeat (count)
        begin
            c.centre_col  = COORD_W'(pick_centre(w));
            c.centre_row  = COORD_W'(pick_centre(h));
            c.radius      = ($urandom_range(0, 9) < 7) ? RAD_W'($urandom_range(0, 8))
                                                       : RAD_W'($urandom_range(0, 15));
            c.paint_value = VALUE_W'($urandom);
            cmd_pending_q.push_back(c);
        end
    endtask

    // wait for every word to be taken and every pixel to arrive, then settle
    task automatic drain();
        do
            @(posedge clk);
        while (cmd_pending_q.size() != 0 || cmd_valid || pixel_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                             input int count, input bit gaps, input bit stalls);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        cmd_gaps_on <= gaps;
        pix_stalls_on <= stalls;
        queue_random(count);
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_cmd(320, 240, 0, 0);
        queue_cmd(320, 240, 1, 32767);
        queue_cmd(0, 0, 8, -32768);
        queue_cmd(639, 479, 8, -1);
        queue_cmd(4095, 4095, 5, 16'h1234);
        queue_cmd(0, 479, 15, 0);
        queue_cmd(639, 0, 9, 16'h5555);
        queue_cmd(100, 100, 0, 1);
        queue_cmd(100, 100, 0, 2);
        queue_cmd(2, 3, 3, 16'hAAAA);
        queue_cmd(638, 1, 2, 16'h00FF);
        queue_cmd(3000, 2000, 4, 16'hFF00);
        queue_cmd(1, 1, 8, 16'h0F0F);
        queue_cmd(2047, 1024, 7, 16'hF0F0);
        queue_cmd(1, 478, 6, 16'h8001);
        drain();

        // hold off the receiver while commands keep coming
        hold_requests <= hold_requests + 1;
        run_phase(13'd16, 13'd16, 55, 1'b0, 1'b1);
        run_phase(13'd4096, 13'd4096, 45, 1'b1, 1'b1);
        write_reg(CFG_UNUSED_LO, 13'd5);
        write_reg(CFG_UNUSED_HI, SIDE_W'($urandom));
        run_phase(13'd0, 13'd8191, 45, 1'b1, 1'b0);
        hold_requests <= hold_requests + 1;
        run_phase(13'd4097, 13'd15, 40, 1'b1, 1'b1);
        run_phase(SIDE_W'($urandom_range(0, 8191)), SIDE_W'($urandom_range(0, 8191)),
                  40, 1'b0, 1'b0);
        run_phase(SIDE_W'($urandom_range(0, 8191)), SIDE_W'($urandom_range(0, 8191)),
                  40, 1'b1, 1'b1);

        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
